// ===== hdl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, silenced during reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, silenced during reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ppsf_pkg.sv =====
// Shared types and constants of the pixel pulse symbol framer.
`default_nettype none

package ppsf_pkg;

    localparam int SLOTS_DEFAULT      = 1024;
    localparam int DATA_WIDTH_DEFAULT = 8;
    localparam int MAX_DATA_WIDTH     = 8;
    localparam int SYMBOL_WIDTH       = 32;
    localparam int OVR_WIDTH          = 16;
    localparam int GAP_WIDTH          = 6;
    localparam int START_WIDTH        = 5;
    localparam int GAP_LIMIT          = 32;
    localparam int QUEUE_DEPTH        = 4;
    localparam int CFG_INDEX_WIDTH    = 3;
    localparam int OUT_DATA_WIDTH     = SYMBOL_WIDTH + OVR_WIDTH;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_ONE_SYMBOL   = 3'd0,
        REG_ZERO_SYMBOL  = 3'd1,
        REG_GAP_SYMBOL   = 3'd2,
        REG_START_SYMBOL = 3'd3,
        REG_IDLE_BITS    = 3'd4,
        REG_START_BITS   = 3'd5,
        REG_STOP_BITS    = 3'd6,
        REG_MSB_FIRST    = 3'd7
    } cfg_reg_t;

    // Settings seen by the back end; gap counts already clamped.
    typedef struct packed {
        logic [SYMBOL_WIDTH-1:0] one_symbol;
        logic [SYMBOL_WIDTH-1:0] zero_symbol;
        logic [SYMBOL_WIDTH-1:0] gap_symbol;
        logic [SYMBOL_WIDTH-1:0] start_symbol;
        logic [GAP_WIDTH-1:0]    idle_cnt;
        logic [START_WIDTH-1:0]  start_cnt;
        logic [GAP_WIDTH-1:0]    stop_cnt;
    } cfg_t;

    // One classified request; bits[0] goes out first.
    typedef struct packed {
        logic                      is_start;
        logic                      final_value;
        logic [MAX_DATA_WIDTH-1:0] bits;
    } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/ppsf_front.sv =====
// Front end: configuration registers and request classification.
`default_nettype none

module ppsf_front #(
    parameter int DATA_WIDTH = ppsf_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [ppsf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [ppsf_pkg::SYMBOL_WIDTH-1:0]    cfg_data,
    input  wire logic                                 in_valid,
    input  wire logic                                 in_func,
    input  wire logic [ppsf_pkg::MAX_DATA_WIDTH-1:0]  in_intensity,
    input  wire logic                                 in_final,
    output logic                                      cmd_valid,
    output ppsf_pkg::cmd_t                            cmd,
    output ppsf_pkg::cfg_t                            cfg
);

    logic [ppsf_pkg::SYMBOL_WIDTH-1:0] one_reg;
    logic [ppsf_pkg::SYMBOL_WIDTH-1:0] zero_reg;
    logic [ppsf_pkg::SYMBOL_WIDTH-1:0] gap_reg;
    logic [ppsf_pkg::SYMBOL_WIDTH-1:0] start_reg;
    logic [ppsf_pkg::GAP_WIDTH-1:0]    idle_reg;
    logic [ppsf_pkg::START_WIDTH-1:0]  start_bits_reg;
    logic [ppsf_pkg::GAP_WIDTH-1:0]    stop_reg;
    logic                              msb_first_reg;
    logic [ppsf_pkg::MAX_DATA_WIDTH-1:0] ordered;

    localparam logic [ppsf_pkg::GAP_WIDTH-1:0] GapMax =
        ppsf_pkg::GAP_WIDTH'(ppsf_pkg::GAP_LIMIT);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_reg        <= '0;
            zero_reg       <= '0;
            gap_reg        <= '0;
            start_reg      <= '0;
            idle_reg       <= '0;
            start_bits_reg <= '0;
            stop_reg       <= '0;
            msb_first_reg  <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (ppsf_pkg::cfg_reg_t'(cfg_index))
                ppsf_pkg::REG_ONE_SYMBOL:   one_reg        <= cfg_data;
                ppsf_pkg::REG_ZERO_SYMBOL:  zero_reg       <= cfg_data;
                ppsf_pkg::REG_GAP_SYMBOL:   gap_reg        <= cfg_data;
                ppsf_pkg::REG_START_SYMBOL: start_reg      <= cfg_data;
                ppsf_pkg::REG_IDLE_BITS:    idle_reg       <= cfg_data[ppsf_pkg::GAP_WIDTH-1:0];
                ppsf_pkg::REG_START_BITS:   start_bits_reg <= cfg_data[ppsf_pkg::START_WIDTH-1:0];
                ppsf_pkg::REG_STOP_BITS:    stop_reg       <= cfg_data[ppsf_pkg::GAP_WIDTH-1:0];
                ppsf_pkg::REG_MSB_FIRST:    msb_first_reg  <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    // Put the data bits in send order so the back end only shifts right.
    always_comb
    begin
        ordered = '0;
        for (int i = 0; i < DATA_WIDTH; i++)
        begin
            ordered[i] = msb_first_reg ? in_intensity[DATA_WIDTH-1-i] : in_intensity[i];
        end
    end

    assign cmd_valid       = in_valid;
    assign cmd.is_start    = !in_func;
    assign cmd.final_value = in_final;
    assign cmd.bits        = ordered;

    assign cfg.one_symbol   = one_reg;
    assign cfg.zero_symbol  = zero_reg;
    assign cfg.gap_symbol   = gap_reg;
    assign cfg.start_symbol = start_reg;
    assign cfg.idle_cnt     = (idle_reg > GapMax) ? GapMax : idle_reg;
    assign cfg.start_cnt    = start_bits_reg;
    assign cfg.stop_cnt     = (stop_reg > GapMax) ? GapMax : stop_reg;

endmodule

`default_nettype wire

// ===== hdl/ppsf_queue.sv =====
// Short request queue between the front end and the back end.
`default_nettype none

module ppsf_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire ppsf_pkg::cmd_t in_cmd,
    output logic                out_valid,
    input  wire logic           out_ready,
    output ppsf_pkg::cmd_t      out_cmd
);

    localparam int Depth = ppsf_pkg::QUEUE_DEPTH;
    localparam int PtrW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    ppsf_pkg::cmd_t  entry_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] fill_reg, fill_next;
    logic            push, pop;

    assign in_ready  = (fill_reg != CntW'(Depth));
    assign out_valid = (fill_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ppsf_back.sv =====
// Back end: symbol sequencer, frame accounting and output register.
`default_nettype none

module ppsf_back #(
    parameter int SLOTS      = ppsf_pkg::SLOTS_DEFAULT,
    parameter int DATA_WIDTH = ppsf_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire ppsf_pkg::cfg_t                      cfg,
    input  wire logic                                q_valid,
    input  wire ppsf_pkg::cmd_t                      q_cmd,
    output logic                                     q_ready,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [ppsf_pkg::OUT_DATA_WIDTH-1:0]      m_axis_tdata,
    output logic                                     m_axis_tlast
);

    localparam int CntW = $clog2(SLOTS);
    localparam logic [CntW-1:0] DataLimit = CntW'(SLOTS - 4);
    localparam logic [CntW-1:0] SymLimit  = CntW'(SLOTS - 2);
    localparam int RemW = ppsf_pkg::GAP_WIDTH;
    localparam logic [RemW-1:0] DataCount = RemW'(DATA_WIDTH);

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_GAP   = 6'b000010,
        PH_START = 6'b000100,
        PH_DATA  = 6'b001000,
        PH_STOP  = 6'b010000,
        PH_TERM  = 6'b100000
    } phase_t;

    phase_t                               phase_reg, phase_next, ph0, ph_e;
    logic [RemW-1:0]                      rem_reg, rem_next, rem0, rem_e;
    logic [ppsf_pkg::MAX_DATA_WIDTH-1:0]  bits_reg, bits_next, bits_e;
    logic                                 final_reg, final_next, final_e;
    logic [CntW-1:0]                      count_reg, count_next, cnt_e;
    logic                                 stopped_reg, stopped_next;
    logic [ppsf_pkg::OVR_WIDTH-1:0]       ovr_reg, ovr_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [ppsf_pkg::SYMBOL_WIDTH-1:0]    out_symbol_reg;
    logic [ppsf_pkg::OVR_WIDTH-1:0]       out_ovr_reg;
    logic                                 out_last_reg;
    logic                                 can_step, load, clear, step, drop, emit;
    logic [ppsf_pkg::SYMBOL_WIDTH-1:0]    sym;

    assign can_step = !out_valid_reg || m_axis_tready;
    assign load     = (phase_reg == PH_IDLE) && q_valid && can_step;
    assign q_ready  = load;
    assign clear    = load && q_cmd.is_start;

    // First phase of the request at the head of the queue.
    always_comb
    begin
        ph0  = PH_IDLE;
        rem0 = '0;
        if (q_cmd.is_start)
        begin
            if (cfg.idle_cnt != '0)
            begin
                ph0  = PH_GAP;
                rem0 = cfg.idle_cnt;
            end
            else if (cfg.start_cnt != '0)
            begin
                ph0  = PH_START;
                rem0 = RemW'(cfg.start_cnt);
            end
        end
        else if (!stopped_reg)
        begin
            if (count_reg < DataLimit)
            begin
                ph0  = PH_DATA;
                rem0 = DataCount;
            end
            else if (q_cmd.final_value)
            begin
                ph0  = (cfg.stop_cnt != '0) ? PH_STOP : PH_TERM;
                rem0 = cfg.stop_cnt;
            end
        end
    end

    // Load and the first step share a cycle.
    always_comb
    begin
        ph_e    = load ? ph0 : phase_reg;
        rem_e   = load ? rem0 : rem_reg;
        bits_e  = load ? q_cmd.bits : bits_reg;
        final_e = load ? q_cmd.final_value : final_reg;
        cnt_e   = clear ? '0 : count_reg;
        step    = can_step && (ph_e != PH_IDLE);
        drop    = (ph_e != PH_TERM) && (cnt_e >= SymLimit);
        emit    = step && !drop;

        case (ph_e)
            PH_GAP, PH_STOP: sym = cfg.gap_symbol;
            PH_START:        sym = cfg.start_symbol;
            PH_DATA:         sym = bits_e[0] ? cfg.one_symbol : cfg.zero_symbol;
            default:         sym = '0;
        endcase

        phase_next   = ph_e;
        rem_next     = rem_e;
        bits_next    = bits_e;
        final_next   = final_e;
        count_next   = cnt_e;
        stopped_next = clear ? 1'b0 : stopped_reg;
        ovr_next     = ovr_reg;

        if (step)
        begin
            if (ph_e != PH_TERM)
            begin
                if (drop)
                begin
                    if (ovr_reg != '1)
                    begin
                        ovr_next = ovr_reg + 1'b1;
                    end
                end
                else
                begin
                    count_next = cnt_e + 1'b1;
                end
            end
            rem_next = rem_e - 1'b1;
            case (ph_e)
                PH_GAP:
                begin
                    if (rem_e == RemW'(1))
                    begin
                        phase_next = (cfg.start_cnt != '0) ? PH_START : PH_IDLE;
                        rem_next   = RemW'(cfg.start_cnt);
                    end
                end
                PH_START:
                begin
                    if (rem_e == RemW'(1))
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_DATA:
                begin
                    bits_next = bits_e >> 1;
                    if (rem_e == RemW'(1))
                    begin
                        if (final_e)
                        begin
                            phase_next = (cfg.stop_cnt != '0) ? PH_STOP : PH_TERM;
                            rem_next   = cfg.stop_cnt;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_STOP:
                begin
                    if (rem_e == RemW'(1))
                    begin
                        phase_next = PH_TERM;
                    end
                end
                PH_TERM:
                begin
                    phase_next   = PH_IDLE;
                    stopped_next = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            rem_reg       <= '0;
            final_reg     <= 1'b0;
            count_reg     <= '0;
            stopped_reg   <= 1'b0;
            ovr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            rem_reg       <= rem_next;
            final_reg     <= final_next;
            count_reg     <= count_next;
            stopped_reg   <= stopped_next;
            ovr_reg       <= ovr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        if (emit)
        begin
            out_symbol_reg <= sym;
            out_ovr_reg    <= ovr_reg;
            out_last_reg   <= (ph_e == PH_TERM);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_ovr_reg, out_symbol_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== hdl/pixel_pulse_symbol_framer_core.sv =====
// Top level of the pixel pulse symbol framer.
// A request with tuser 0 opens a frame: it emits the idle gap symbols and then the
// start symbols, one per cycle unless the output stalls. A request with tuser 1
// carries an intensity in tdata[7:0] and emits DATA_WIDTH one/zero symbols, the
// first one in the cycle the sequencer picks it up; with tlast set it also emits
// the stop gap symbols and a zero terminator word marked with tlast. A data request
// emits nothing once its frame is closed, and no data symbols once it has no data room.
// Each symbol slot, emitted or dropped for lack of frame room, is a sequencer step.
// Requests wait in a four-entry queue, so input keeps flowing until the queue fills,
// also while the output register waits to be taken. Configuration writes are taken every cycle.
`default_nettype none

module pixel_pulse_symbol_framer_core #(
    parameter int SLOTS      = ppsf_pkg::SLOTS_DEFAULT,
    parameter int DATA_WIDTH = ppsf_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [ppsf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [ppsf_pkg::SYMBOL_WIDTH-1:0]    cfg_data,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [ppsf_pkg::MAX_DATA_WIDTH-1:0]  s_axis_tdata,   // [7:0] intensity
    input  wire logic                                 s_axis_tuser,   // [0] func
    input  wire logic                                 s_axis_tlast,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [ppsf_pkg::OUT_DATA_WIDTH-1:0]       m_axis_tdata,   // [31:0] symbol, [47:32] overrun_total
    output logic                                      m_axis_tlast
);

    ppsf_pkg::cfg_t cfg;
    ppsf_pkg::cmd_t front_cmd;
    ppsf_pkg::cmd_t queue_cmd;
    logic           front_valid;
    logic           queue_valid;
    logic           queue_ready;

    ppsf_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (s_axis_tvalid),
        .in_func      (s_axis_tuser),
        .in_intensity (s_axis_tdata),
        .in_final     (s_axis_tlast),
        .cmd_valid    (front_valid),
        .cmd          (front_cmd),
        .cfg          (cfg)
    );

    ppsf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (s_axis_tready),
        .in_cmd    (front_cmd),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_cmd   (queue_cmd)
    );

    ppsf_back #(
        .SLOTS      (SLOTS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_valid       (queue_valid),
        .q_cmd         (queue_cmd),
        .q_ready       (queue_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== hdl/ppsf_checker.sv =====
// Port-level checker of the framer top level and its bind.
`default_nettype none
`include "assert_macros.svh"

module ppsf_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 m_axis_tvalid,
    input wire logic                                 m_axis_tready,
    input wire logic [ppsf_pkg::OUT_DATA_WIDTH-1:0]  m_axis_tdata,
    input wire logic                                 m_axis_tlast
);

    `ASSERT_NEXT(a_out_hold_valid, clk, rst_n,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid,
        "output request dropped while stalled")

    `ASSERT_NEXT(a_out_hold_data, clk, rst_n,
        m_axis_tvalid && !m_axis_tready,
        $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "output payload changed while stalled")

    // A second terminator needs a new frame and at least one data symbol first.
    `ASSERT_NEXT(a_single_terminator, clk, rst_n,
        m_axis_tvalid && m_axis_tready && m_axis_tlast,
        !(m_axis_tvalid && m_axis_tlast),
        "terminators back to back")

    // The overrun tally only grows between consecutive results.
    `ASSERT_IMPL(a_overrun_monotonic, clk, rst_n,
        $past(m_axis_tvalid && m_axis_tready) && m_axis_tvalid,
        m_axis_tdata[ppsf_pkg::OUT_DATA_WIDTH-1:ppsf_pkg::SYMBOL_WIDTH] >=
            $past(m_axis_tdata[ppsf_pkg::OUT_DATA_WIDTH-1:ppsf_pkg::SYMBOL_WIDTH]),
        "overrun tally went down")

endmodule

bind pixel_pulse_symbol_framer_core ppsf_checker u_ppsf_checker (.*);

`default_nettype wire

// ===== test/pixel_pulse_symbol_framer_core_checker.sv =====
// Checker for the pulse symbol framer: predicts each request's symbol words and compares them.
`timescale 1ns / 1ps

module pixel_pulse_symbol_framer_core_checker #(
    parameter int SLOTS      = ppsf_pkg::SLOTS_DEFAULT,
    parameter int DATA_WIDTH = ppsf_pkg::DATA_WIDTH_DEFAULT,
    parameter bit START_FUNC = 1'b0
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [ppsf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [ppsf_pkg::SYMBOL_WIDTH-1:0]    cfg_data,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic [ppsf_pkg::MAX_DATA_WIDTH-1:0]  s_axis_tdata,   // [7:0] intensity
    input  logic                                 s_axis_tuser,   // [0] func
    input  logic                                 s_axis_tlast,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [ppsf_pkg::OUT_DATA_WIDTH-1:0]  m_axis_tdata,   // [31:0] symbol, [47:32] overrun_total
    input  logic                                 m_axis_tlast,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   words_checked,
    output logic [ppsf_pkg::OVR_WIDTH-1:0]       overrun_total
);

    typedef struct packed {
        logic [ppsf_pkg::SYMBOL_WIDTH-1:0] symbol;
        logic                              frame_end;
        logic [ppsf_pkg::OVR_WIDTH-1:0]    overrun;
    } symbol_word_t;

    symbol_word_t                      word_q[$];

    logic [ppsf_pkg::SYMBOL_WIDTH-1:0] one_sym;
    logic [ppsf_pkg::SYMBOL_WIDTH-1:0] zero_sym;
    logic [ppsf_pkg::SYMBOL_WIDTH-1:0] gap_sym;
    logic [ppsf_pkg::SYMBOL_WIDTH-1:0] start_sym;
    logic [ppsf_pkg::GAP_WIDTH-1:0]    idle_cnt;
    logic [ppsf_pkg::START_WIDTH-1:0]  start_cnt;
    logic [ppsf_pkg::GAP_WIDTH-1:0]    stop_cnt;
    logic                              msb_first;
    int unsigned                       frame_count;
    logic                              frame_closed;

    function automatic int unsigned clamp_gap(logic [ppsf_pkg::GAP_WIDTH-1:0] n);
        return (n > ppsf_pkg::GAP_LIMIT) ? ppsf_pkg::GAP_LIMIT : n;
    endfunction

    // Append one expected word at the tail of the queue.
    function automatic void add_word(symbol_word_t w);
        word_q = {word_q, w};
    endfunction

    // Drop the symbol once the frame is out of room, else count and queue it.
    function automatic void put_symbol(logic [ppsf_pkg::SYMBOL_WIDTH-1:0] sym);
        if (frame_count >= SLOTS - 2) begin
            if (overrun_total != '1)
                overrun_total++;
        end
        else begin
            frame_count++;
            add_word(symbol_word_t'{sym, 1'b0, overrun_total});
        end
    endfunction

    function automatic void encode_request(logic func,
                                           logic [ppsf_pkg::MAX_DATA_WIDTH-1:0] value,
                                           logic fin);
        int unsigned k;
        int unsigned pos;
        if (func == START_FUNC) begin
            frame_count  = 0;
            frame_closed = 1'b0;
            for (k = 0; k < clamp_gap(idle_cnt); k++)
                put_symbol(gap_sym);
            for (k = 0; k < start_cnt; k++)
                put_symbol(start_sym);
        end
        else if (!frame_closed) begin
            // A full frame takes no more data bits; a final request still closes it.
            if (frame_count < SLOTS - 4) begin
                for (k = 0; k < DATA_WIDTH; k++) begin
                    pos = msb_first ? DATA_WIDTH - 1 - k : k;
                    put_symbol(value[pos] ? one_sym : zero_sym);
                end
            end
            if (fin) begin
                for (k = 0; k < clamp_gap(stop_cnt); k++)
                    put_symbol(gap_sym);
                // Terminator is never counted and never dropped.
                add_word(symbol_word_t'{'0, 1'b1, overrun_total});
                frame_closed = 1'b1;
            end
        end
    endfunction

    function automatic void check_field(string name,
                                        logic [ppsf_pkg::SYMBOL_WIDTH-1:0] want_v,
                                        logic [ppsf_pkg::SYMBOL_WIDTH-1:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        symbol_word_t got;
        symbol_word_t want;
        if (!rst_n) begin
            one_sym       = '0;
            zero_sym      = '0;
            gap_sym       = '0;
            start_sym     = '0;
            idle_cnt      = '0;
            start_cnt     = '0;
            stop_cnt      = '0;
            msb_first     = 1'b1;
            frame_count   = 0;
            frame_closed  = 1'b0;
            overrun_total = '0;
            fail_count    = 0;
            words_checked = 0;
            word_q.delete();
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (ppsf_pkg::cfg_reg_t'(cfg_index))
                    ppsf_pkg::REG_ONE_SYMBOL:   one_sym   = cfg_data;
                    ppsf_pkg::REG_ZERO_SYMBOL:  zero_sym  = cfg_data;
                    ppsf_pkg::REG_GAP_SYMBOL:   gap_sym   = cfg_data;
                    ppsf_pkg::REG_START_SYMBOL: start_sym = cfg_data;
                    ppsf_pkg::REG_IDLE_BITS:    idle_cnt  = cfg_data[ppsf_pkg::GAP_WIDTH-1:0];
                    ppsf_pkg::REG_START_BITS:   start_cnt = cfg_data[ppsf_pkg::START_WIDTH-1:0];
                    ppsf_pkg::REG_STOP_BITS:    stop_cnt  = cfg_data[ppsf_pkg::GAP_WIDTH-1:0];
                    ppsf_pkg::REG_MSB_FIRST:    msb_first = cfg_data[0];
                    default: ;
                endcase
            end
            // Predict before comparing so a same-edge request is already queued.
            if (s_axis_tvalid && s_axis_tready)
                encode_request(s_axis_tuser, s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                got.symbol    = m_axis_tdata[ppsf_pkg::SYMBOL_WIDTH-1:0];
                got.frame_end = m_axis_tlast;
                got.overrun   = m_axis_tdata[ppsf_pkg::OUT_DATA_WIDTH-1:ppsf_pkg::SYMBOL_WIDTH];
                if (word_q.size() == 0) begin
                    $display("%0t: symbol word %h (last %b) with nothing expected",
                             $time, got.symbol, got.frame_end);
                    fail_count++;
                end
                else begin
                    want = word_q.pop_front();
                    check_field("symbol", want.symbol, got.symbol);
                    check_field("frame_end", ppsf_pkg::SYMBOL_WIDTH'(want.frame_end),
                                ppsf_pkg::SYMBOL_WIDTH'(got.frame_end));
                    check_field("overrun_total", ppsf_pkg::SYMBOL_WIDTH'(want.overrun),
                                ppsf_pkg::SYMBOL_WIDTH'(got.overrun));
                    words_checked++;
                end
            end
        end
        pending = word_q.size();
    end

endmodule

// ===== test/pixel_pulse_symbol_framer_core_tb.sv =====
// Testbench top for the pulse symbol framer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module pixel_pulse_symbol_framer_core_tb;

    localparam logic FUNC_START    = 1'b0;
    localparam logic FUNC_DATA     = 1'b1;
    localparam int   DRAIN_CYCLES  = 64;
    localparam int   HOLD_CYCLES   = 400;
    localparam int   CYCLE_LIMIT   = 1_500_000;
    localparam int   RANDOM_PHASES = 9;
    localparam int   PHASE_ITEMS   = 36;

    logic                                 clk           = 1'b0;
    logic                                 rst_n         = 1'b0;
    logic                                 cfg_valid     = 1'b0;
    logic                                 cfg_ready;
    logic [ppsf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index     = '0;
    logic [ppsf_pkg::SYMBOL_WIDTH-1:0]    cfg_data      = '0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    logic [ppsf_pkg::MAX_DATA_WIDTH-1:0]  s_axis_tdata  = '0;
    logic                                 s_axis_tuser  = 1'b0;
    logic                                 s_axis_tlast  = 1'b0;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic [ppsf_pkg::OUT_DATA_WIDTH-1:0]  m_axis_tdata;
    logic                                 m_axis_tlast;

    int                                   fail_count;
    int                                   pending;
    int                                   words_checked;
    logic [ppsf_pkg::OVR_WIDTH-1:0]       overrun_total;

    int                                   items_sent    = 0;
    int                                   settings_used = 0;
    int                                   cycle_count   = 0;
    bit                                   hold_req      = 1'b0;
    bit                                   no_idle       = 1'b0;

    pixel_pulse_symbol_framer_core i_dut (.*);

    pixel_pulse_symbol_framer_core_checker #(
        .START_FUNC(FUNC_START)
    ) i_checker (.*);

    initial begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending);
            $display("pixel_pulse_symbol_framer_core_tb: done, errors");
            $finish;
        end
    end

    // Output side: ready bursts, random stalls, and one long hold-off on request.
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!no_idle && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
            else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge clk);
            end
        end
    end

    task automatic send_item(input logic func, input logic [ppsf_pkg::MAX_DATA_WIDTH-1:0] value,
                             input logic fin);
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= value;
        s_axis_tlast  <= fin;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        items_sent++;
    endtask

    // Hold input, wait for every expected word, then let resultless requests finish.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input ppsf_pkg::cfg_reg_t idx,
                             input logic [ppsf_pkg::SYMBOL_WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic set_regs(input logic [ppsf_pkg::SYMBOL_WIDTH-1:0] one_w, zero_w, gap_w,
                            start_w,
                            input logic [ppsf_pkg::GAP_WIDTH-1:0] idle_n,
                            input logic [ppsf_pkg::START_WIDTH-1:0] start_n,
                            input logic [ppsf_pkg::GAP_WIDTH-1:0] stop_n, input logic msb);
        write_reg(ppsf_pkg::REG_ONE_SYMBOL, one_w);
        write_reg(ppsf_pkg::REG_ZERO_SYMBOL, zero_w);
        write_reg(ppsf_pkg::REG_GAP_SYMBOL, gap_w);
        write_reg(ppsf_pkg::REG_START_SYMBOL, start_w);
        write_reg(ppsf_pkg::REG_IDLE_BITS, 32'(idle_n));
        write_reg(ppsf_pkg::REG_START_BITS, 32'(start_n));
        write_reg(ppsf_pkg::REG_STOP_BITS, 32'(stop_n));
        write_reg(ppsf_pkg::REG_MSB_FIRST, 32'(msb));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [ppsf_pkg::SYMBOL_WIDTH-1:0] rand_word();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic set_random_regs();
        logic [ppsf_pkg::GAP_WIDTH-1:0]   idle_n;
        logic [ppsf_pkg::START_WIDTH-1:0] start_n;
        logic [ppsf_pkg::GAP_WIDTH-1:0]   stop_n;
        case ($urandom_range(0, 5))
            0:       idle_n = 0;
            1:       idle_n = ppsf_pkg::GAP_LIMIT;
            2:       idle_n = '1;
            default: idle_n = $urandom_range(1, 6);
        endcase
        case ($urandom_range(0, 4))
            0:       start_n = 0;
            1:       start_n = '1;
            default: start_n = $urandom_range(1, 4);
        endcase
        case ($urandom_range(0, 5))
            0:       stop_n = 0;
            1:       stop_n = ppsf_pkg::GAP_LIMIT;
            2:       stop_n = $urandom_range(ppsf_pkg::GAP_LIMIT + 1, 63);
            default: stop_n = $urandom_range(1, 6);
        endcase
        set_regs(rand_word(), rand_word(), rand_word(), rand_word(), idle_n, start_n, stop_n,
                 $urandom_range(0, 1));
    endtask

    // Mostly whole frames with random content, the rest stray or broken requests.
    task automatic random_traffic(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 4) != 0) begin
                len = $urandom_range(1, 6);
                send_item(FUNC_START, $urandom, $urandom_range(0, 1));
                repeat (len - 1) send_item(FUNC_DATA, $urandom, 1'b0);
                send_item(FUNC_DATA, $urandom, 1'b1);
                sent += len + 1;
            end
            else begin
                send_item($urandom_range(0, 1), $urandom, $urandom_range(0, 1));
                sent++;
            end
        end
    endtask

    // Overfill one frame: the 127th value is cut short, later values and all stop
    // symbols are dropped, and the terminator still goes out.
    task automatic long_frame();
        settle();
        set_regs(rand_word(), rand_word(), $urandom, $urandom, 6'd7, 5'd0, ppsf_pkg::GAP_LIMIT,
                 $urandom_range(0, 1));
        send_item(FUNC_START, $urandom, 1'b0);
        for (int k = 0; k < 129; k++) begin
            if (k == 20)
                hold_req = 1'b1;
            send_item(FUNC_DATA, $urandom, 1'b0);
        end
        send_item(FUNC_DATA, $urandom, 1'b1);
        send_item(FUNC_DATA, $urandom, 1'b1);
    endtask

    initial begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: data with no start item, then a closed frame and an empty start.
        send_item(FUNC_DATA, 8'hFF, 1'b0);
        send_item(FUNC_DATA, 8'h00, 1'b1);
        send_item(FUNC_DATA, 8'h5A, 1'b1);
        send_item(FUNC_START, 8'h00, 1'b0);
        settle();

        // Gap counts above the limit, widest start run, MSB first.
        set_regs('1, '0, 32'hAAAA_AAAA, 32'h5555_5555, '1, '1, 6'd40, 1'b1);
        send_item(FUNC_START, 8'hFF, 1'b1);
        send_item(FUNC_DATA, 8'h00, 1'b0);
        send_item(FUNC_DATA, 8'hFF, 1'b0);
        send_item(FUNC_DATA, 8'h80, 1'b0);
        send_item(FUNC_DATA, 8'h01, 1'b0);
        send_item(FUNC_DATA, 8'hA5, 1'b1);
        send_item(FUNC_DATA, 8'h3C, 1'b0);
        settle();

        // No gaps, no start or stop symbols, LSB first.
        set_regs(32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF, 32'h0F0F_F0F0, 6'd0, 5'd0, 6'd0,
                 1'b0);
        send_item(FUNC_START, 8'h00, 1'b0);
        send_item(FUNC_DATA, 8'h80, 1'b0);
        send_item(FUNC_DATA, 8'h01, 1'b1);
        send_item(FUNC_START, 8'h7E, 1'b1);
        send_item(FUNC_DATA, 8'hC3, 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 4)
                long_frame();
            if (p == RANDOM_PHASES - 1)
                no_idle = 1'b1;
            settle();
            set_random_regs();
            random_traffic(PHASE_ITEMS);
        end
        settle();

        $display("%0d requests sent under %0d register settings, %0d symbol words checked",
                 items_sent, settings_used, words_checked);
        $display("frame overflow dropped %0d symbols in total", overrun_total);
        if (fail_count == 0 && pending == 0)
            $display("pixel_pulse_symbol_framer_core_tb: done, clean");
        else
            $display("pixel_pulse_symbol_framer_core_tb: done, errors");
        $finish;
    end

endmodule
